@@ design/opbe_pkg.sv @@
// Shared types, constants and helper functions of the orthogonal polynomial basis evaluator.
package opbe_pkg;

	localparam int MAX_TERMS   = 16;
	localparam int CNT_W       = 5;
	localparam int IDX_W       = 4;
	localparam int VAL_W       = 16;
	localparam int SLP_W       = 24;
	localparam int VAL_MAX     = 16384;
	localparam int SLP_MAX     = 4194304;
	localparam int ONE_Q14     = 16384;
	localparam int FRAC_BITS   = 14;
	localparam int MUL_A_W     = 32;
	localparam int MUL_B_W     = 28;
	localparam int PROD_W      = MUL_A_W + MUL_B_W;
	localparam int SAT_IN_W    = 42;
	localparam int QUO_W       = 21;
	localparam int RECIP_W     = 27;
	localparam int RECIP_SHIFT = 26;

	localparam logic [0:0] REG_BASIS_SELECT = 1'b0;
	localparam logic [0:0] REG_TERM_COUNT   = 1'b1;

	localparam logic BASIS_CHEBYSHEV = 1'b0;
	localparam logic BASIS_LEGENDRE  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CALC,
		ST_C1,
		ST_C2,
		ST_L1,
		ST_L2,
		ST_L3,
		ST_L4,
		ST_L5,
		ST_EMIT
	} opbe_state_t;

	typedef struct packed {
		logic             basis_select;
		logic [CNT_W-1:0] term_count;
	} opbe_cfg_t;

	typedef struct packed {
		logic                    valid;
		logic [IDX_W-1:0]        term_index;
		logic signed [VAL_W-1:0] poly_value;
		logic signed [SLP_W-1:0] poly_slope;
		logic                    last_term;
	} opbe_res_t;

	// ceil(2^26 / n): exact floor division by n for dividends below 2^21
	function automatic logic [RECIP_W-1:0] recip(input logic [IDX_W-1:0] n);
		logic [RECIP_W-1:0] r;
		case (n)
			4'd1:    r = 27'd67108864;
			4'd2:    r = 27'd33554432;
			4'd3:    r = 27'd22369622;
			4'd4:    r = 27'd16777216;
			4'd5:    r = 27'd13421773;
			4'd6:    r = 27'd11184811;
			4'd7:    r = 27'd9586981;
			4'd8:    r = 27'd8388608;
			4'd9:    r = 27'd7456541;
			4'd10:   r = 27'd6710887;
			4'd11:   r = 27'd6100806;
			4'd12:   r = 27'd5592406;
			4'd13:   r = 27'd5162221;
			4'd14:   r = 27'd4793491;
			4'd15:   r = 27'd4473925;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SAT_IN_W-1:0] v);
		logic signed [VAL_W-1:0] r;
		if (v > SAT_IN_W'(VAL_MAX)) begin
			r = VAL_W'(VAL_MAX);
		end else if (v < -SAT_IN_W'(VAL_MAX)) begin
			r = -VAL_W'(VAL_MAX);
		end else begin
			r = VAL_W'(v);
		end
		return r;
	endfunction

	function automatic logic signed [SLP_W-1:0] sat_slp(input logic signed [SAT_IN_W-1:0] v);
		logic signed [SLP_W-1:0] r;
		if (v > SAT_IN_W'(SLP_MAX)) begin
			r = SLP_W'(SLP_MAX);
		end else if (v < -SAT_IN_W'(SLP_MAX)) begin
			r = -SLP_W'(SLP_MAX);
		end else begin
			r = SLP_W'(v);
		end
		return r;
	endfunction

endpackage

@@ design/opbe_mul.sv @@
// Shared signed multiplier with a registered product.
module opbe_mul
	import opbe_pkg::*;
(
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [PROD_W-1:0]  p
);

	logic signed [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign p = p_q;

endmodule

@@ design/opbe_core.sv @@
// Recurrence sequencer: steps the shared multiplier through each term and rounds, divides, saturates.
module opbe_core
	import opbe_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [VAL_W-1:0] point_x,
	input  opbe_cfg_t               cfg,
	input  logic                    out_free,
	output logic                    idle,
	output opbe_res_t               res
);

	opbe_state_t state_q, state_d;

	logic [CNT_W-1:0]        n_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    sel_q;
	logic signed [VAL_W-1:0] x_q;
	logic signed [VAL_W-1:0] vp_q, vp2_q, v_q;
	logic signed [SLP_W-1:0] sp_q, sp2_q, s_q;
	logic signed [34:0]      acc_q;
	logic [QUO_W-1:0]        m_q;
	logic                    neg_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  p;

	logic                    last;
	logic [CNT_W:0]          two_n_m1;
	logic [CNT_W-1:0]        n_m1;
	logic signed [VAL_W-1:0] x_clamp;
	logic [CNT_W-1:0]        cnt_clamp;

	logic signed [34:0] cheb_vn;
	logic signed [41:0] cheb_sn;
	logic signed [35:0] leg_vn;
	logic [35:0]        leg_mag;
	logic [35:0]        leg_m_sum;
	logic signed [25:0] leg_sn;
	logic [QUO_W-1:0]   leg_q;
	logic signed [SAT_IN_W-1:0] leg_v;

	opbe_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (p)
	);

	assign last     = ((n_q + 5'd1) == cnt_q);
	assign two_n_m1 = {n_q, 1'b0} - 6'd1;
	assign n_m1     = n_q - 5'd1;

	always_comb begin
		if (point_x > 16'(VAL_MAX)) begin
			x_clamp = 16'(VAL_MAX);
		end else if (point_x < -16'(VAL_MAX)) begin
			x_clamp = -16'(VAL_MAX);
		end else begin
			x_clamp = point_x;
		end
		if (cfg.term_count == '0) begin
			cnt_clamp = 5'd1;
		end else if (cfg.term_count > CNT_W'(MAX_TERMS)) begin
			cnt_clamp = CNT_W'(MAX_TERMS);
		end else begin
			cnt_clamp = cfg.term_count;
		end
	end

	// recurrence arithmetic on the product that is ready this cycle
	always_comb begin
		cheb_vn   = (35'(p) <<< 1) - (35'(vp2_q) <<< FRAC_BITS) + 35'sd8192;
		cheb_sn   = (42'(p) <<< 1) + (42'(vp_q) <<< (FRAC_BITS + 1))
		            - (42'(sp2_q) <<< FRAC_BITS) + 42'sd8192;
		leg_vn    = 36'(acc_q) - (36'(p) <<< FRAC_BITS);
		leg_mag   = leg_vn[35] ? 36'(-leg_vn) : 36'(leg_vn);
		leg_m_sum = (leg_mag + (36'(n_q) << (FRAC_BITS - 1))) >> FRAC_BITS;
		leg_sn    = 26'(sp2_q) + 26'(p);
		leg_q     = p[RECIP_SHIFT +: QUO_W];
		leg_v     = neg_q ? -$signed(SAT_IN_W'(leg_q)) : $signed(SAT_IN_W'(leg_q));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_CALC;
			end
			ST_CALC: begin
				if (n_q < 5'd2) begin
					state_d = ST_EMIT;
				end else if (sel_q == BASIS_LEGENDRE) begin
					state_d = ST_L1;
				end else begin
					state_d = ST_C1;
				end
			end
			ST_C1: state_d = ST_C2;
			ST_C2: state_d = ST_EMIT;
			ST_L1: state_d = ST_L2;
			ST_L2: state_d = ST_L3;
			ST_L3: state_d = ST_L4;
			ST_L4: state_d = ST_L5;
			ST_L5: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) state_d = last ? ST_IDLE : ST_CALC;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// multiplier operands and result strobe
	always_comb begin
		mul_a          = '0;
		mul_b          = '0;
		idle           = 1'b0;
		res.valid      = 1'b0;
		res.term_index = n_q[IDX_W-1:0];
		res.poly_value = v_q;
		res.poly_slope = s_q;
		res.last_term  = last;
		case (state_q)
			ST_IDLE: idle = 1'b1;
			ST_CALC: begin
				mul_a = 32'(x_q);
				mul_b = 28'(vp_q);
			end
			ST_C1: begin
				mul_a = 32'(x_q);
				mul_b = 28'(sp_q);
			end
			ST_L1: begin
				mul_a = 32'(p);
				mul_b = $signed(28'(two_n_m1));
			end
			ST_L2: begin
				mul_a = 32'(vp2_q);
				mul_b = $signed(28'(n_m1));
			end
			ST_L3: begin
				mul_a = 32'(vp_q);
				mul_b = $signed(28'(two_n_m1));
			end
			ST_L4: begin
				mul_a = $signed(32'(m_q));
				mul_b = $signed(28'(recip(n_q[IDX_W-1:0])));
			end
			ST_EMIT: res.valid = out_free;
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && start) begin
				n_q <= '0;
			end else if (state_q == ST_EMIT && out_free) begin
				n_q <= n_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					x_q   <= x_clamp;
					cnt_q <= cnt_clamp;
					sel_q <= cfg.basis_select;
				end
			end
			ST_CALC: begin
				if (n_q == 5'd0) begin
					v_q <= 16'(ONE_Q14);
					s_q <= '0;
				end else if (n_q == 5'd1) begin
					v_q <= x_q;
					s_q <= 24'(ONE_Q14);
				end
			end
			ST_C1: v_q <= sat_val(SAT_IN_W'(cheb_vn >>> FRAC_BITS));
			ST_C2: s_q <= sat_slp(SAT_IN_W'(cheb_sn >>> FRAC_BITS));
			ST_L2: acc_q <= 35'(p);
			ST_L3: begin
				m_q   <= leg_m_sum[QUO_W-1:0];
				neg_q <= leg_vn[35];
			end
			ST_L4: s_q <= sat_slp(SAT_IN_W'(leg_sn));
			ST_L5: v_q <= sat_val(leg_v);
			ST_EMIT: begin
				if (out_free) begin
					vp2_q <= vp_q;
					vp_q  <= v_q;
					sp2_q <= sp_q;
					sp_q  <= s_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ design/orthogonal_poly_basis_eval.sv @@
// Top level of the orthogonal polynomial basis evaluator: ports, configuration, output register.
//
// Each accepted point x (signed Q2.14, clamped to +-1.0) yields a run of term_count results,
// degrees 0 up to term_count-1 (a count of zero gives one term, counts above 16 give 16), each
// with the polynomial value (Q2.14) and derivative (Q10.14), both saturated; tlast marks the
// final term. basis_select picks Chebyshev (0) or Legendre (1). All products go through one
// shared registered multiplier, so the per-term time is set by how many times the recurrence
// uses it: degrees 0 and 1 are loaded directly, higher degrees use it twice for Chebyshev and
// five times for Legendre (the last multiply dividing by the degree through a reciprocal), and
// a stalled output holds the next term back. s_tready is low from the transaction until the
// last term has been loaded into the output register.
module orthogonal_poly_basis_eval
	import opbe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] point_x
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [3:0] term_index, [19:4] poly_value, [43:20] poly_slope
	output logic        m_tlast,   // last_term
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [4:0]  cfg_data
);

	opbe_cfg_t cfg_q;
	opbe_res_t res;

	logic                    idle;
	logic                    start;
	logic                    out_free;
	logic                    m_tvalid_q;
	logic [IDX_W-1:0]        idx_q;
	logic signed [VAL_W-1:0] value_q;
	logic signed [SLP_W-1:0] slope_q;
	logic                    last_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = idle;
	assign start     = s_tvalid && idle;
	assign out_free  = !m_tvalid_q || m_tready;

	opbe_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.point_x  ($signed(s_tdata)),
		.cfg      (cfg_q),
		.out_free (out_free),
		.idle     (idle),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.basis_select <= BASIS_CHEBYSHEV;
			cfg_q.term_count   <= CNT_W'(MAX_TERMS);
			m_tvalid_q         <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_BASIS_SELECT: cfg_q.basis_select <= cfg_data[0];
					REG_TERM_COUNT:   cfg_q.term_count   <= cfg_data;
					default:          cfg_q              <= cfg_q;
				endcase
			end
			if (res.valid) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// hold the result until the downstream side takes it
	always_ff @(posedge clk) begin
		if (res.valid) begin
			idx_q   <= res.term_index;
			value_q <= res.poly_value;
			slope_q <= res.poly_slope;
			last_q  <= res.last_term;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, slope_q, value_q, idx_q};
	assign m_tlast  = last_q;

	a_no_result_while_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !s_tready)
		else $error("result produced while the core reports idle");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.last_term) |=> s_tready)
		else $error("core not idle after the last term of a run");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("core still ready after accepting a point");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the orthogonal polynomial basis evaluator.
module testbench
	import opbe_pkg::*;
();

	localparam int HOLD_CYCLES  = 600;
	localparam int CALM_BATCH   = 2;
	localparam int HOLD_BATCH   = 5;
	localparam int RAND_BATCHES = 9;
	localparam int BATCH_POINTS = 15;
	localparam int SETTLE       = 20;
	localparam int REPORT_MAX   = 10;

	typedef struct {
		logic [IDX_W-1:0]        idx;
		logic signed [VAL_W-1:0] value;
		logic signed [SLP_W-1:0] slope;
		logic                    last;
	} basis_term_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;      // [15:0] point_x
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;           // [3:0] term_index, [19:4] poly_value, [43:20] poly_slope
	logic        m_tlast;           // last_term
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = REG_BASIS_SELECT;
	logic [4:0]  cfg_data = '0;

	logic [VAL_W-1:0] pending_points[$];
	basis_term_t      expected_terms[$];

	logic             shadow_basis = BASIS_CHEBYSHEV;
	logic [CNT_W-1:0] shadow_terms = CNT_W'(MAX_TERMS);

	logic calm = 1'b0;
	logic hold_go = 1'b0;
	logic hold_active = 1'b0;

	int points_queued = 0;
	int points_accepted = 0;
	int chebyshev_points = 0;
	int legendre_points = 0;
	int terms_checked = 0;
	int reg_writes = 0;
	int mismatch_count = 0;

	orthogonal_poly_basis_eval u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint clip(input longint v, input longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// Q.28 -> Q.14, nearest with ties toward +infinity
	function automatic longint round_q14(input longint v);
		return (v + longint'(ONE_Q14 / 2)) >>> FRAC_BITS;
	endfunction

	// nearest with ties away from zero
	function automatic longint div_round_away(input longint v, input longint d);
		longint mag;
		longint q;
		mag = (v < 0) ? -v : v;
		q = (mag + d / 2) / d;
		return (v < 0) ? -q : q;
	endfunction

	// Run the recurrence for one point under the current registers and queue every term.
	function automatic void predict_terms(input logic [VAL_W-1:0] raw);
		longint x, v, s, vp, vp2, sp, sp2, num, k;
		int count;
		basis_term_t entry;
		x = clip(longint'($signed(raw)), ONE_Q14);
		count = int'(shadow_terms);
		if (count == 0) count = 1;
		if (count > MAX_TERMS) count = MAX_TERMS;
		vp = 0;
		vp2 = 0;
		sp = 0;
		sp2 = 0;
		for (int n = 0; n < count; n++) begin
			k = longint'(n);
			if (n == 0) begin
				v = ONE_Q14;
				s = 0;
			end else if (n == 1) begin
				v = x;
				s = ONE_Q14;
			end else if (shadow_basis == BASIS_CHEBYSHEV) begin
				num = 2 * x * vp - vp2 * ONE_Q14;
				v = clip(round_q14(num), VAL_MAX);
				num = 2 * x * sp + 2 * vp * ONE_Q14 - sp2 * ONE_Q14;
				s = clip(round_q14(num), SLP_MAX);
			end else begin
				num = (2 * k - 1) * x * vp - (k - 1) * vp2 * ONE_Q14;
				v = clip(div_round_away(num, k * ONE_Q14), VAL_MAX);
				s = clip(sp2 + (2 * k - 1) * vp, SLP_MAX);
			end
			vp2 = vp;
			vp = v;
			sp2 = sp;
			sp = s;
			entry.idx = IDX_W'(n);
			entry.value = VAL_W'(v);
			entry.slope = SLP_W'(s);
			entry.last = (n + 1 == count);
			expected_terms.push_back(entry);
		end
	endfunction

	function automatic void note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX) $display("%s", msg);
	endfunction

	// point driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (pending_points.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_points.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_active) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 16);
		end
	end

	// long receiver hold-off so the block backs up and stalls its input
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_active <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active <= 1'b0;
	end

	// monitor: track registers, predict on each point, check each term
	always @(posedge clk) begin : monitor
		basis_term_t want;
		logic [IDX_W-1:0] got_idx;
		logic [VAL_W-1:0] got_val;
		logic [SLP_W-1:0] got_slp;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BASIS_SELECT: shadow_basis = cfg_data[0];
					REG_TERM_COUNT:   shadow_terms = cfg_data;
					default: ;
				endcase
				reg_writes++;
			end
			if (s_tvalid && s_tready) begin
				predict_terms(s_tdata);
				points_accepted++;
				if (shadow_basis == BASIS_CHEBYSHEV) chebyshev_points++;
				else legendre_points++;
			end
			if (m_tvalid && m_tready) begin
				got_idx = m_tdata[3:0];
				got_val = m_tdata[19:4];
				got_slp = m_tdata[43:20];
				if (expected_terms.size() == 0) begin
					note_failure($sformatf("unexpected term: idx %0d value %0d slope %0d last %0b",
						got_idx, $signed(got_val), $signed(got_slp), m_tlast));
				end else begin
					want = expected_terms.pop_front();
					terms_checked++;
					if (got_idx !== want.idx || got_val !== want.value || got_slp !== want.slope
						|| m_tlast !== want.last || m_tdata[47:44] !== '0) begin
						note_failure($sformatf({"term mismatch: expected idx %0d value %0d slope %0d",
							" last %0b, got idx %0d value %0d slope %0d last %0b pad %h"},
							want.idx, want.value, want.slope, want.last, got_idx,
							$signed(got_val), $signed(got_slp), m_tlast, m_tdata[47:44]));
					end
				end
			end
		end
	end

	task automatic write_reg(input logic [0:0] idx, input logic [CNT_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic basis, input logic [CNT_W-1:0] terms);
		write_reg(REG_BASIS_SELECT, CNT_W'(basis));
		write_reg(REG_TERM_COUNT, terms);
	endtask

	task automatic push_point(input logic [VAL_W-1:0] p);
		pending_points.push_back(p);
		points_queued++;
	endtask

	// wait until every point is taken and every term has come back
	task automatic drain();
		while (points_accepted < points_queued || expected_terms.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [VAL_W-1:0] random_point();
		if ($urandom_range(4) == 0) return VAL_W'($urandom_range(65535));
		return VAL_W'(int'($urandom_range(2 * ONE_Q14)) - ONE_Q14);
	endfunction

	int directed_x[10] = '{0, 16384, -16384, 32767, -32768, 16385, -16383, 8192, -1, 11585};

	initial begin
		logic             basis;
		logic [CNT_W-1:0] terms;
		int               pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: both families over the field extremes, then zero, small and oversized term counts
		configure(BASIS_CHEBYSHEV, CNT_W'(MAX_TERMS));
		foreach (directed_x[i]) push_point(VAL_W'(directed_x[i]));
		drain();
		configure(BASIS_LEGENDRE, CNT_W'(MAX_TERMS));
		foreach (directed_x[i]) push_point(VAL_W'(directed_x[i]));
		drain();
		configure(BASIS_LEGENDRE, CNT_W'(0));
		push_point(VAL_W'(-16384));
		drain();
		configure(BASIS_CHEBYSHEV, CNT_W'(31));
		push_point(VAL_W'(32767));
		drain();
		configure(BASIS_CHEBYSHEV, CNT_W'(1));
		push_point(VAL_W'(5000));
		drain();
		configure(BASIS_LEGENDRE, CNT_W'(17));
		push_point(VAL_W'(-9000));
		drain();
		configure(BASIS_LEGENDRE, CNT_W'(2));
		push_point(VAL_W'(12345));
		drain();

		// random batches, one with no idling and one with a long output stall
		for (int b = 0; b < RAND_BATCHES; b++) begin
			basis = logic'($urandom_range(1));
			pick = $urandom_range(9);
			if (pick <= 5) terms = CNT_W'($urandom_range(MAX_TERMS, 1));
			else if (pick <= 7) terms = CNT_W'($urandom_range(4, 1));
			else if (pick == 8) terms = ($urandom_range(1) == 0) ? '0 : CNT_W'(MAX_TERMS);
			else terms = CNT_W'($urandom_range(31, MAX_TERMS + 1));
			if (b == HOLD_BATCH) terms = CNT_W'(MAX_TERMS);
			configure(basis, terms);
			calm = (b == CALM_BATCH);
			if (b == HOLD_BATCH) hold_go = 1'b1;
			for (int i = 0; i < BATCH_POINTS; i++) push_point(random_point());
			drain();
			calm = 1'b0;
		end

		repeat (SETTLE) @(posedge clk);
		if (expected_terms.size() != 0)
			note_failure($sformatf("%0d terms never arrived", expected_terms.size()));
		$display("covered %0d points (%0d Chebyshev, %0d Legendre), %0d terms checked",
			points_accepted, chebyshev_points, legendre_points, terms_checked);
		$display("%0d register writes, %0d mismatches", reg_writes, mismatch_count);
		if (mismatch_count == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

	initial begin
		#6000000;
		$display("timeout with %0d terms outstanding", expected_terms.size());
		$display("testbench: FAIL");
		$finish;
	end

endmodule
